// ----- design/itrd_pkg.sv -----
// Package for the integer to radix digits converter.
// Holds the default word width, the character codes and the digit-to-ASCII map.
// No dependencies; imported by every module of the block.
package itrd_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int BASE_W        = 6;
  localparam int CHAR_W        = 7;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;

  // Digits 0 to 9 map to '0'..'9', digits 10 to 35 to 'a'..'z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_A + {1'b0, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

// ----- design/itrd_div_unit.sv -----
// Shared divide-by-base unit: quotient and remainder of a word by a small base.
// Uses a reciprocal multiply and one correction step; go is registered into vld1_r, then into done.
// Depends on itrd_pkg.
module itrd_div_unit #(
  parameter int W = itrd_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [W-1:0]              v_in,
  input  logic [itrd_pkg::BASE_W-1:0] base_in,
  output logic                      done,
  output logic [W-1:0]              quot,
  output logic [itrd_pkg::BASE_W-1:0] rem
);
  import itrd_pkg::*;

  localparam logic [W:0] TwoPowW = {1'b1, {W{1'b0}}};

  logic [W-1:0]    recip_nxt;
  logic [W-1:0]    recip_r;
  logic [2*W-1:0]  prod_r;
  logic [W-1:0]    v1_r;
  logic            vld1_r;
  logic [W-1:0]    q_est;
  logic [W+BASE_W-1:0] qb_full;
  logic [W-1:0]    r_est;
  logic            fix;
  logic            done_r;
  logic [W-1:0]    quot_r;
  logic [BASE_W-1:0] rem_r;

  // floor(2^W / base): the estimate below is then the quotient or one less.
  always_comb begin
    case (base_in)
      6'd2:  recip_nxt = W'(TwoPowW / 2);
      6'd3:  recip_nxt = W'(TwoPowW / 3);
      6'd4:  recip_nxt = W'(TwoPowW / 4);
      6'd5:  recip_nxt = W'(TwoPowW / 5);
      6'd6:  recip_nxt = W'(TwoPowW / 6);
      6'd7:  recip_nxt = W'(TwoPowW / 7);
      6'd8:  recip_nxt = W'(TwoPowW / 8);
      6'd9:  recip_nxt = W'(TwoPowW / 9);
      6'd10: recip_nxt = W'(TwoPowW / 10);
      6'd11: recip_nxt = W'(TwoPowW / 11);
      6'd12: recip_nxt = W'(TwoPowW / 12);
      6'd13: recip_nxt = W'(TwoPowW / 13);
      6'd14: recip_nxt = W'(TwoPowW / 14);
      6'd15: recip_nxt = W'(TwoPowW / 15);
      6'd16: recip_nxt = W'(TwoPowW / 16);
      6'd17: recip_nxt = W'(TwoPowW / 17);
      6'd18: recip_nxt = W'(TwoPowW / 18);
      6'd19: recip_nxt = W'(TwoPowW / 19);
      6'd20: recip_nxt = W'(TwoPowW / 20);
      6'd21: recip_nxt = W'(TwoPowW / 21);
      6'd22: recip_nxt = W'(TwoPowW / 22);
      6'd23: recip_nxt = W'(TwoPowW / 23);
      6'd24: recip_nxt = W'(TwoPowW / 24);
      6'd25: recip_nxt = W'(TwoPowW / 25);
      6'd26: recip_nxt = W'(TwoPowW / 26);
      6'd27: recip_nxt = W'(TwoPowW / 27);
      6'd28: recip_nxt = W'(TwoPowW / 28);
      6'd29: recip_nxt = W'(TwoPowW / 29);
      6'd30: recip_nxt = W'(TwoPowW / 30);
      6'd31: recip_nxt = W'(TwoPowW / 31);
      6'd32: recip_nxt = W'(TwoPowW / 32);
      6'd33: recip_nxt = W'(TwoPowW / 33);
      6'd34: recip_nxt = W'(TwoPowW / 34);
      6'd35: recip_nxt = W'(TwoPowW / 35);
      6'd36: recip_nxt = W'(TwoPowW / 36);
      default: recip_nxt = '0;
    endcase
  end

  always_comb begin
    q_est   = prod_r[2*W-1:W];
    qb_full = q_est * base_in;
    r_est   = v1_r - qb_full[W-1:0];
    fix     = (r_est >= W'(base_in));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      vld1_r <= go;
      done_r <= vld1_r;
    end
    recip_r <= recip_nxt;
    if (go) begin
      prod_r <= v_in * recip_r;
      v1_r   <= v_in;
    end
    if (vld1_r) begin
      if (fix) begin
        quot_r <= q_est + W'(1);
        rem_r  <= BASE_W'(r_est - W'(base_in));
      end else begin
        quot_r <= q_est;
        rem_r  <= r_est[BASE_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ----- design/integer_to_radix_digits_core.sv -----
// Integer to radix digits converter: digits come one at a time from a shared divide unit,
// digits kept in a small memory and sent out most significant first, one per cycle.
// A conversion has at most WORD_BITS digits, the depth of that memory; busy
// falls in the cycle of the last character, and a request is taken only while busy is low.
// A bad base answers with one character in the cycle after the request, busy never rises.
// Reset is synchronous, active low; it idles the sequencer and clears the strobes.
module integer_to_radix_digits_core #(
  parameter int WORD_BITS = itrd_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [WORD_BITS-1:0]          in_value,
  input  logic                          in_mode,
  input  logic [itrd_pkg::BASE_W-1:0]   in_base,
  output logic                          out_valid,
  output logic [itrd_pkg::CHAR_W-1:0]   out_text_char,
  output logic                          out_last,
  output logic                          out_bad_base
);
  import itrd_pkg::*;

  localparam int AW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ISSUE, S_WAIT, S_EMIT, S_DRAIN
  } state_t;

  state_t            state_r;
  logic [BASE_W-1:0] base_r;
  logic [WORD_BITS-1:0] v_r;
  logic              neg_r;
  logic              sign_pend_r;
  logic [AW-1:0]     wr_idx_r;
  logic [AW-1:0]     rd_idx_r;
  logic              rd_vld_r;
  logic              rd_last_r;
  logic [CHAR_W-1:0] rd_q_r;
  logic [CHAR_W-1:0] mem [WORD_BITS];

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              out_bad_r;

  logic              accept;
  logic              base_ok;
  logic              in_neg;
  logic [WORD_BITS-1:0] in_mag;
  logic              div_go;
  logic [WORD_BITS-1:0] div_v;
  logic              div_done;
  logic [WORD_BITS-1:0] div_q;
  logic [BASE_W-1:0] div_r;
  logic              mem_we;
  logic              q_zero;

  assign accept  = start && (state_r == S_IDLE);
  assign base_ok = (in_base inside {[BASE_MIN:BASE_MAX]});
  assign in_neg  = !in_mode && in_value[WORD_BITS-1];
  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign in_mag  = in_neg ? (WORD_BITS'(0) - in_value) : in_value;

  assign q_zero = (div_q == '0);
  assign mem_we = (state_r == S_WAIT) && div_done;
  assign div_go = (state_r == S_ISSUE) || (mem_we && !q_zero);
  assign div_v  = (state_r == S_ISSUE) ? v_r : div_q;

  itrd_div_unit #(.W(WORD_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (div_go),
    .v_in   (div_v),
    .base_in(base_r),
    .done   (div_done),
    .quot   (div_q),
    .rem    (div_r)
  );

  // Digits arrive least significant first and are read back in reverse.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= digit_char(div_r);
    end
    rd_q_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      sign_pend_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (base_ok) begin
              base_r   <= in_base;
              v_r      <= in_mag;
              neg_r    <= in_neg;
              wr_idx_r <= '0;
              state_r  <= S_PREP;
            end else begin
              out_valid_r <= 1'b1;
              out_char_r  <= CHAR_NUL;
              out_last_r  <= 1'b1;
              out_bad_r   <= 1'b1;
            end
          end
        end
        // The divide unit latches its reciprocal from the new base here.
        S_PREP: begin
          state_r <= S_ISSUE;
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            if (q_zero) begin
              rd_idx_r    <= wr_idx_r;
              sign_pend_r <= neg_r;
              state_r     <= S_EMIT;
            end else begin
              wr_idx_r <= wr_idx_r + AW'(1);
            end
          end
        end
        S_EMIT: begin
          rd_vld_r  <= 1'b1;
          rd_last_r <= (rd_idx_r == '0);
          rd_idx_r  <= rd_idx_r - AW'(1);
          if (sign_pend_r) begin
            out_valid_r <= 1'b1;
            out_char_r  <= CHAR_MINUS;
            out_last_r  <= 1'b0;
            out_bad_r   <= 1'b0;
            sign_pend_r <= 1'b0;
          end
          if (rd_idx_r == '0) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (rd_vld_r) begin
        out_valid_r <= 1'b1;
        out_char_r  <= rd_q_r;
        out_last_r  <= rd_last_r;
        out_bad_r   <= 1'b0;
      end
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;
  assign out_bad_base  = out_bad_r;

endmodule

// ----- design/itrd_checker.sv -----
// Port-level checks for the integer to radix digits converter.
// Bound to integer_to_radix_digits_core; depends on itrd_pkg.
module itrd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [itrd_pkg::CHAR_W-1:0] out_text_char,
  input logic                        out_last,
  input logic                        out_bad_base
);
  import itrd_pkg::*;

  // The characters of one conversion come without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a conversion");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_base |-> out_last && (out_text_char == CHAR_NUL))
    else $error("bad base result malformed");

  // A request either starts a conversion or is answered at once as a bad base.
  a_request: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || (out_valid && out_bad_base))
    else $error("request neither started nor rejected");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("conversion ended before its last character");

  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind integer_to_radix_digits_core itrd_checker u_itrd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_text_char(out_text_char),
  .out_last     (out_last),
  .out_bad_base (out_bad_base)
);

// ----- test/itrd_checker.sv -----
// Checker for the integer to radix digits converter: watches the request and
// character ports, predicts the text of each accepted request and compares it.
// Depends on itrd_pkg for the widths and the character codes.
module itrd_scoreboard
  import itrd_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [WORD_BITS-1:0] in_value,
  input  logic                 in_mode,
  input  logic [BASE_W-1:0]    in_base,
  input  logic                 out_valid,
  input  logic [CHAR_W-1:0]    out_text_char,
  input  logic                 out_last,
  input  logic                 out_bad_base,
  output int                   mismatches,
  output int                   chars_pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last;
    logic              bad_base;
  } text_char_t;

  text_char_t pending_text[$];

  // Appends the characters of one conversion, most significant first.
  function automatic void predict_text(input logic [WORD_BITS-1:0] value,
                                       input logic mode, input logic [BASE_W-1:0] base);
    logic [WORD_BITS-1:0] mag;
    logic [WORD_BITS-1:0] rem;
    logic [CHAR_W-1:0]    rev_chars[WORD_BITS];
    logic                 negative;
    int                   n;
    if (base < BASE_MIN || base > BASE_MAX) begin
      pending_text.push_back('{CHAR_NUL, 1'b1, 1'b1});
      return;
    end
    negative = !mode && value[WORD_BITS-1];
    // Negating the most negative word wraps back to itself, which read
    // unsigned is exactly its magnitude.
    mag = negative ? (~value + 1'b1) : value;
    n = 0;
    do begin
      rem = mag % base;
      mag = mag / base;
      if (rem < 10) begin
        rev_chars[n] = CHAR_ZERO + rem[CHAR_W-1:0];
      end else begin
        rev_chars[n] = CHAR_A + rem[CHAR_W-1:0] - 7'd10;
      end
      n++;
    end while (mag != 0);
    if (negative) begin
      pending_text.push_back('{CHAR_MINUS, 1'b0, 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      pending_text.push_back('{rev_chars[i], i == 0, 1'b0});
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      pending_text.delete();
      mismatches = 0;
      chars_pending <= 0;
    end else begin
      if (start && !busy) begin
        predict_text(in_value, in_mode, in_base);
      end
      if (out_valid) begin
        if (pending_text.size() == 0) begin
          $display("%0t: character with no request pending: char %h last %b bad_base %b",
                   $time, out_text_char, out_last, out_bad_base);
          mismatches++;
        end else begin
          want = pending_text.pop_front();
          if (out_text_char !== want.text_char) begin
            $display("%0t: text_char expected %h got %h", $time, want.text_char, out_text_char);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, out_last);
            mismatches++;
          end
          if (out_bad_base !== want.bad_base) begin
            $display("%0t: bad_base expected %b got %b", $time, want.bad_base, out_bad_base);
            mismatches++;
          end
        end
      end
      chars_pending <= pending_text.size();
    end
  end

endmodule

// ----- test/integer_to_radix_digits_core_tb.sv -----
// Testbench top for integer_to_radix_digits_core: drives directed and random
// conversion requests with random gaps and gives the verdict from itrd_scoreboard.
// Depends on itrd_pkg, the block and test/itrd_checker.sv.
module integer_to_radix_digits_core_tb;
  import itrd_pkg::*;

  localparam int WORD_BITS = WORD_BITS_DEF;
  localparam int RANDOM_REQUESTS = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [WORD_BITS-1:0] in_value = '0;
  logic                 in_mode = 1'b0;
  logic [BASE_W-1:0]    in_base = '0;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_text_char;
  logic                 out_last;
  logic                 out_bad_base;
  int                   mismatches;
  int                   chars_pending;
  bit                   back_to_back = 1'b0;

  integer_to_radix_digits_core #(.WORD_BITS(WORD_BITS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .in_base       (in_base),
    .out_valid     (out_valid),
    .out_text_char (out_text_char),
    .out_last      (out_last),
    .out_bad_base  (out_bad_base)
  );

  itrd_scoreboard #(.WORD_BITS(WORD_BITS)) u_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .in_base       (in_base),
    .out_valid     (out_valid),
    .out_text_char (out_text_char),
    .out_last      (out_last),
    .out_bad_base  (out_bad_base),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Called right after a rising edge; returns at the edge that accepts the request.
  task automatic send_request(input logic [WORD_BITS-1:0] value, input logic mode,
                              input logic [BASE_W-1:0] base);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= value;
    in_mode  <= mode;
    in_base  <= base;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_text();
    start <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  function automatic logic [WORD_BITS-1:0] pick_value();
    logic [WORD_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 1000);
      2: v = $urandom >> $urandom_range(0, 31);
      default: v = {1'b1, {(WORD_BITS-1){1'b0}}} | ($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  initial begin
    logic [BASE_W-1:0] base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bases outside the valid range.
    send_request(32'd123, 1'b0, 6'd0);
    send_request(32'd123, 1'b1, 6'd1);
    send_request(32'd123, 1'b0, 6'd37);
    send_request(32'hffff_ffff, 1'b1, 6'd63);
    // Zero, the longest texts and the most negative word.
    send_request(32'd0, 1'b0, 6'd2);
    send_request(32'd0, 1'b1, 6'd36);
    send_request(32'hffff_ffff, 1'b1, 6'd2);
    send_request(32'h8000_0000, 1'b0, 6'd2);
    send_request(32'h8000_0000, 1'b0, 6'd10);
    send_request(32'h8000_0000, 1'b1, 6'd10);
    send_request(32'h7fff_ffff, 1'b0, 6'd36);
    send_request(32'hffff_ffff, 1'b0, 6'd16);
    send_request(32'hffff_ffff, 1'b1, 6'd3);
    // Single digits at the edges of the digit set.
    send_request(32'd35, 1'b0, 6'd36);
    send_request(32'd9, 1'b1, 6'd10);
    send_request(32'd10, 1'b0, 6'd11);
    send_request(32'd1234567890, 1'b0, 6'd10);
    send_request(32'hdead_beef, 1'b1, 6'd16);
    send_request(32'hdead_beef, 1'b0, 6'd8);
    drain_text();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      back_to_back = (i % 60) < 15;
      if (i == RANDOM_REQUESTS / 2) begin
        drain_text();
      end
      if ($urandom_range(0, 7) == 0) begin
        base = BASE_W'($urandom_range(0, 63));
      end else begin
        base = BASE_W'($urandom_range(2, 36));
      end
      send_request(pick_value(), 1'($urandom_range(0, 1)), base);
    end

    drain_text();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
